// ===== hw/rtl/oars_pkg.sv =====
// Package for the ordered array relational search block.
// Holds beat payload types, controller/datapath link types and code constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package oars_pkg;

  localparam int POS_W   = 10;
  localparam int VAL_W   = 32;
  localparam int REL_W   = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [REL_W-1:0] REL_LT = 3'd0;
  localparam logic [REL_W-1:0] REL_LE = 3'd1;
  localparam logic [REL_W-1:0] REL_EQ = 3'd2;
  localparam logic [REL_W-1:0] REL_GT = 3'd3;
  localparam logic [REL_W-1:0] REL_GE = 3'd4;

  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXACT     = 2'd1;
  localparam logic [STAT_W-1:0] ST_LESS      = 2'd2;
  localparam logic [STAT_W-1:0] ST_GREATER   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_ASC   = 1'd1;

  typedef struct packed {
    logic                    operation;
    logic [POS_W-1:0]        write_position;
    logic signed [VAL_W-1:0] write_value;
    logic signed [VAL_W-1:0] search_key;
    logic [REL_W-1:0]        relation;
  } oars_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  found_position;
  } oars_res_t;

  typedef struct packed {
    logic write_entry;
    logic start_query;
    logic read;
  } oars_cmd_t;

  typedef struct packed {
    logic is_query;
    logic skip;
    logic last_addr;
  } oars_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/oars_ctrl.sv =====
// Controller for the ordered array relational search block.
// Sequences write beats and query scans; depends on oars_pkg.
`timescale 1ns / 1ps
`default_nettype none
module oars_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire oars_pkg::oars_sts_t sts,
  output oars_pkg::oars_cmd_t    cmd,
  output logic                   busy,
  output logic                   done
);
  import oars_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_t;

  state_t state;

  always_comb begin
    cmd.write_entry = (state == S_IDLE) && start && !sts.is_query;
    cmd.start_query = (state == S_IDLE) && start && sts.is_query;
    cmd.read        = (state == S_SCAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && sts.is_query) begin
            if (sts.skip) begin
              done <= 1'b1;
            end else begin
              state <= S_SCAN;
              busy  <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (sts.last_addr) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/oars_dpath.sv =====
// Datapath for the ordered array relational search block.
// Entry memory, config registers, scan address, compare and best-match tracking.
// Depends on oars_pkg.
`timescale 1ns / 1ps
`default_nettype none
module oars_dpath #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire oars_pkg::oars_req_t           request,
  input  wire logic                          cfg_we,
  input  wire logic [oars_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [oars_pkg::CFG_W-1:0]    cfg_data,
  input  wire oars_pkg::oars_cmd_t           cmd,
  output oars_pkg::oars_sts_t                sts,
  output oars_pkg::oars_res_t                result
);
  import oars_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic signed [VAL_W-1:0] mem [0:MAX_ENTRIES-1];

  logic [COUNT_W-1:0]      entry_count;
  logic                    order_ascending;

  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           last_a;
  logic signed [VAL_W-1:0] rd_data;
  logic                    rd_vld;
  logic [AW-1:0]           cmp_idx;

  logic signed [VAL_W-1:0] key_q;
  logic [REL_W-1:0]        rel_q;
  logic                    take_largest;

  logic                    found;
  logic [AW-1:0]           best_idx;
  logic [STAT_W-1:0]       best_status;

  logic [CW-1:0]           n_sat;
  logic [CW-1:0]           n_sat_m1;
  logic [AW+CW-1:0]        nm1_ext;
  logic [AW+POS_W-1:0]     wpos_ext;
  logic                    wr_ok;
  logic [AW+POS_W-1:0]     idx_ext;
  logic                    qual;
  logic                    eq;
  logic [STAT_W-1:0]       cand_status;

  always_comb begin
    if (32'(entry_count) > 32'(MAX_ENTRIES)) begin
      n_sat = CW'(MAX_ENTRIES);
    end else begin
      n_sat = CW'(entry_count);
    end
    n_sat_m1 = n_sat - CW'(1);
    nm1_ext  = {AW'(0), n_sat_m1};
    wpos_ext = {AW'(0), request.write_position};
    wr_ok    = 32'(request.write_position) < 32'(MAX_ENTRIES);
    idx_ext  = {POS_W'(0), best_idx};
  end

  always_comb begin
    sts.is_query  = (request.operation == OP_QUERY);
    sts.skip      = (n_sat == '0) || (request.relation > REL_GE);
    sts.last_addr = (rd_addr == last_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count     <= COUNT_W'(1);
      order_ascending <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTRY_COUNT: entry_count     <= cfg_data[COUNT_W-1:0];
        CFG_ORDER_ASC:   order_ascending <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.write_entry && wr_ok) begin
      mem[wpos_ext[AW-1:0]] <= request.write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      rd_addr <= '0;
      last_a  <= nm1_ext[AW-1:0];
      key_q   <= request.search_key;
      rel_q   <= request.relation;
      if (order_ascending) begin
        take_largest <= (request.relation <= REL_LE);
      end else begin
        take_largest <= (request.relation >= REL_EQ);
      end
    end else if (cmd.read) begin
      rd_addr <= rd_addr + AW'(1);
      cmp_idx <= rd_addr;
    end
  end

  always_comb begin
    eq = (rd_data == key_q);
    unique case (rel_q)
      REL_LT: begin
        qual        = rd_data < key_q;
        cand_status = ST_LESS;
      end
      REL_LE: begin
        qual        = rd_data <= key_q;
        cand_status = eq ? ST_EXACT : ST_LESS;
      end
      REL_EQ: begin
        qual        = eq;
        cand_status = ST_EXACT;
      end
      REL_GT: begin
        qual        = rd_data > key_q;
        cand_status = ST_GREATER;
      end
      REL_GE: begin
        qual        = rd_data >= key_q;
        cand_status = eq ? ST_EXACT : ST_GREATER;
      end
      default: begin
        qual        = 1'b0;
        cand_status = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      found       <= 1'b0;
      best_idx    <= '0;
      best_status <= ST_NOT_FOUND;
    end else if (rd_vld && qual && (take_largest || !found)) begin
      found       <= 1'b1;
      best_idx    <= cmp_idx;
      best_status <= cand_status;
    end
  end

  always_comb begin
    result.status         = best_status;
    result.found_position = idx_ext[POS_W-1:0];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ordered_array_relational_search.sv =====
// Top level of the ordered array relational search block.
// Joins the controller (oars_ctrl) and the datapath (oars_dpath); depends on oars_pkg.
//
// A beat is taken when start is high and busy is low. A write beat stores one
// entry in the same cycle and gives no result; busy stays low. A query beat
// scans entries 0 to count-1, one read of the entry memory per cycle, and
// returns one result: done is high for exactly one cycle with status and
// found_position valid, and the receiver cannot stall it. A count above
// MAX_ENTRIES scans MAX_ENTRIES entries. A query holds busy while it reads
// the entries and while it compares the last entry, and done is high in
// the first cycle that busy is low again, so the next beat may start in the
// cycle done is shown. A query with a count of zero or an undefined relation
// answers not found in the cycle after the beat, without a scan. Configuration
// writes take effect at once and belong between queries.
`timescale 1ns / 1ps
`default_nettype none
module ordered_array_relational_search #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire oars_pkg::oars_req_t            request,
  output logic                                busy,
  output logic                                done,
  output oars_pkg::oars_res_t                 result,
  input  wire logic                           cfg_we,
  input  wire logic [oars_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [oars_pkg::CFG_W-1:0]     cfg_data
);
  import oars_pkg::*;

  oars_cmd_t cmd;
  oars_sts_t sts;

  oars_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  oars_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule
`default_nettype wire

// ===== tb/oars_checker.sv =====
// Checker for the ordered array relational search block: keeps its own copy of the
// entry table and registers, predicts each query answer and compares it. Uses oars_pkg.
`timescale 1ns / 1ps
module oars_checker #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  oars_pkg::oars_req_t                 request,
  input  logic                                done,
  input  oars_pkg::oars_res_t                 result,
  input  logic                                cfg_we,
  input  logic [oars_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [oars_pkg::CFG_W-1:0]          cfg_data,
  output int                                  mismatches,
  output int                                  answers_open
);
  import oars_pkg::*;

  logic signed [VAL_W-1:0] stored_val [MAX_ENTRIES];
  logic [COUNT_W-1:0]      entry_count;
  logic                    ascending;
  oars_res_t               answers_due [$];
  oars_res_t               want;

  function automatic oars_res_t predict_answer(logic signed [VAL_W-1:0] key,
                                               logic [REL_W-1:0] rel);
    int        span;
    int        pick;
    logic      take_last;
    logic      hit;
    logic      found;
    oars_res_t ans;
    span = (entry_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_count);
    take_last = ascending ? (rel <= REL_LE) : (rel >= REL_EQ);
    found = 1'b0;
    pick = 0;
    if (rel <= REL_GE) begin
      for (int i = 0; i < span; i++) begin
        case (rel)
          REL_LT:  hit = stored_val[i] < key;
          REL_LE:  hit = stored_val[i] <= key;
          REL_EQ:  hit = stored_val[i] == key;
          REL_GT:  hit = stored_val[i] > key;
          default: hit = stored_val[i] >= key;
        endcase
        if (hit && (take_last || !found)) begin
          found = 1'b1;
          pick = i;
        end
      end
    end
    ans.status = ST_NOT_FOUND;
    ans.found_position = '0;
    if (found) begin
      ans.found_position = POS_W'(pick);
      case (rel)
        REL_LT:  ans.status = ST_LESS;
        REL_LE:  ans.status = (stored_val[pick] == key) ? ST_EXACT : ST_LESS;
        REL_EQ:  ans.status = ST_EXACT;
        REL_GT:  ans.status = ST_GREATER;
        default: ans.status = (stored_val[pick] == key) ? ST_EXACT : ST_GREATER;
      endcase
    end
    return ans;
  endfunction

  task automatic flag_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      entry_count = COUNT_W'(1);
      ascending = 1'b1;
      answers_due.delete();
      answers_open <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENTRY_COUNT: entry_count = cfg_data;
          CFG_ORDER_ASC:   ascending = cfg_data[0];
          default: ;
        endcase
      end
      if (done) begin
        if (answers_due.size() == 0) begin
          flag_mismatch($sformatf("answer with no query waiting (status %0d, position %0d)",
                                  result.status, result.found_position));
        end else begin
          want = answers_due.pop_front();
          if (result.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", result.status, want.status));
          if (result.found_position !== want.found_position)
            flag_mismatch($sformatf("position %0d, want %0d",
                                    result.found_position, want.found_position));
        end
      end
      if (start && !busy) begin
        if (request.operation == OP_WRITE)
          stored_val[request.write_position] = request.write_value;
        else
          answers_due.push_back(predict_answer(request.search_key, request.relation));
      end
      answers_open <= answers_due.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the ordered array relational search testbench: clock, reset, stimulus and verdict.
// Instantiates the block and oars_checker; uses oars_pkg.
`timescale 1ns / 1ps
module tb_top;
  import oars_pkg::*;

  localparam int MAX_ENTRIES = 1024;
  localparam int CYCLE_LIMIT = 1500000;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  oars_req_t            request = '0;
  logic                 busy;
  logic                 done;
  oars_res_t            result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ENTRY_COUNT;
  logic [CFG_W-1:0]     cfg_data = '0;

  int                      mismatches;
  int                      answers_open;
  int                      cycle_cnt = 0;
  int                      queries_sent = 0;
  int                      phase = 0;
  int                      span;
  int                      sel;
  logic                    calm = 1'b0;
  logic                    laid_asc = 1'b1;
  logic [CFG_W-1:0]        count_set;
  logic                    asc_set;
  logic signed [VAL_W-1:0] shadow [MAX_ENTRIES];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ordered_array_relational_search #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  oars_checker #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .answers_open(answers_open)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic oars_req_t noise_beat();
    oars_req_t b;
    b.operation = 1'($urandom);
    b.write_position = POS_W'($urandom);
    b.write_value = $urandom;
    b.search_key = $urandom;
    b.relation = REL_W'($urandom);
    return b;
  endfunction

  function automatic oars_req_t write_beat(int pos, logic signed [VAL_W-1:0] val);
    oars_req_t b;
    b = noise_beat();
    b.operation = OP_WRITE;
    b.write_position = POS_W'(pos);
    b.write_value = val;
    return b;
  endfunction

  function automatic oars_req_t query_beat(logic signed [VAL_W-1:0] key,
                                           logic [REL_W-1:0] rel);
    oars_req_t b;
    b = noise_beat();
    b.operation = OP_QUERY;
    b.search_key = key;
    b.relation = rel;
    return b;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_key(int n);
    int at;
    at = $urandom_range(0, ((n > 0) ? n : MAX_ENTRIES) - 1);
    case ($urandom_range(0, 9))
      5:       return shadow[at] + 1;
      6:       return shadow[at] - 1;
      7:       return $urandom;
      8:       return VAL_MIN;
      9:       return VAL_MAX;
      default: return shadow[at];
    endcase
  endfunction

  function automatic logic [REL_W-1:0] pick_rel();
    int r;
    r = $urandom_range(0, 9);
    if (r < 9)
      return REL_W'(r % (REL_GE + 1));
    return REL_W'($urandom_range(REL_GE + 1, (1 << REL_W) - 1));
  endfunction

  task automatic hold_off(int n);
    start <= 1'b0;
    request <= noise_beat();
    repeat (n) @(posedge clk);
  endtask

  task automatic push_beat(oars_req_t beat);
    if (!calm && $urandom_range(0, 5) == 0)
      hold_off($urandom_range(1, 10));
    start <= 1'b1;
    request <= beat;
    do @(posedge clk); while (busy);
    if (beat.operation == OP_QUERY)
      queries_sent++;
  endtask

  task automatic store(int pos, logic signed [VAL_W-1:0] val);
    shadow[pos] = val;
    push_beat(write_beat(pos, val));
  endtask

  task automatic ask(logic signed [VAL_W-1:0] key, logic [REL_W-1:0] rel);
    push_beat(query_beat(key, rel));
  endtask

  // hold until every answer is in, then let the block settle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (answers_open != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [CFG_W-1:0] count, logic asc);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ENTRY_COUNT;
    cfg_data <= count;
    @(posedge clk);
    cfg_index <= CFG_ORDER_ASC;
    cfg_data <= CFG_W'({$urandom_range(0, 1023), asc});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // fill entries 0..n-1 in sorted order, spread over the full range or dense with repeats
  task automatic lay_out(int n, logic asc);
    longint                  v;
    longint                  stride_max;
    logic signed [VAL_W-1:0] vals [MAX_ENTRIES];
    if ($urandom_range(0, 1)) begin
      stride_max = 64'd4294967295 / n;
      v = longint'(VAL_MIN) + $urandom_range(0, 15);
    end else begin
      stride_max = 3;
      v = longint'(int'($urandom)) / 2;
    end
    for (int i = 0; i < n; i++) begin
      vals[i] = v[VAL_W-1:0];
      v += $urandom_range(0, 32'(stride_max));
    end
    for (int i = 0; i < n; i++)
      store(asc ? i : n - 1 - i, vals[i]);
    if (n == MAX_ENTRIES)
      laid_asc = asc;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset registers: one entry, ascending
    store(MAX_ENTRIES - 1, VAL_MAX);
    store(0, VAL_MIN);
    ask(VAL_MIN, REL_EQ);
    ask(VAL_MIN, REL_LT);
    ask(VAL_MIN, REL_LE);
    ask(VAL_MIN, REL_GT);
    ask(VAL_MIN, REL_GE);
    ask('0, REL_LT);
    ask('0, REL_GT);
    for (int r = REL_GE + 1; r < (1 << REL_W); r++)
      ask(VAL_MIN, REL_W'(r));
    store(0, VAL_MAX);
    ask(VAL_MAX, REL_GE);
    ask(VAL_MIN, REL_GT);
    ask(VAL_MAX, REL_LT);
    ask(VAL_MIN, REL_LE);
    ask(VAL_MAX, REL_EQ);
    ask(VAL_MAX, REL_LE);
    drain();

    lay_out(MAX_ENTRIES, 1'b1);

    while (queries_sent < 380) begin
      case (phase)
        0: begin count_set = '1;                  asc_set = 1'b1; end
        1: begin count_set = '0;                  asc_set = 1'b0; end
        2: begin count_set = CFG_W'(MAX_ENTRIES); asc_set = 1'b0; end
        3: begin count_set = CFG_W'(1);           asc_set = 1'b0; end
        default: begin
          asc_set = 1'($urandom);
          sel = $urandom_range(0, 19);
          case (sel)
            0:       count_set = '0;
            1:       count_set = CFG_W'(MAX_ENTRIES);
            2:       count_set = CFG_W'($urandom_range(MAX_ENTRIES + 1, (1 << CFG_W) - 1));
            3:       count_set = CFG_W'(1);
            default: count_set = CFG_W'($urandom_range(2, 16));
          endcase
        end
      endcase
      calm = (queries_sent > 320) || ($urandom_range(0, 3) == 0);
      drain();
      set_config(count_set, asc_set);
      span = (count_set > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_set);
      if (span > 0 && (span < MAX_ENTRIES || asc_set != laid_asc))
        lay_out(span, asc_set);
      repeat ((span >= 64) ? $urandom_range(3, 5) : $urandom_range(10, 20)) begin
        if ($urandom_range(0, 7) == 0)
          store($urandom_range(0, MAX_ENTRIES - 1), $urandom);
        else
          ask(pick_key(span), pick_rel());
      end
      phase++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && answers_open == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
